// ===== rtl/pidcc_pkg.sv =====
// pidcc_pkg: shared widths, register indexes and handshake structs of the
// clamped pid controller core. Depends on nothing; used by every rtl file.
package pidcc_pkg;

  localparam int DATA_W    = 32;
  localparam int TIME_W    = 31;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_UPPER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LOWER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_UPPER = 3'd6;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic  en;
    data_t a;
    data_t b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/pidcc_mul.sv =====
// pidcc_mul: shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on pidcc_pkg.
module pidcc_mul (
  input  logic                clk,
  input  pidcc_pkg::mul_req_t req,
  output pidcc_pkg::prod_t    prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= $signed(req.a) * $signed(req.b);
    end
  end

endmodule

// ===== rtl/pidcc_div.sv =====
// pidcc_div: unsigned restoring divider, two quotient bits per cycle.
// Depends on pidcc_pkg.
module pidcc_div (
  input  logic                clk,
  input  logic                rst,
  input  pidcc_pkg::div_req_t req,
  output pidcc_pkg::div_rsp_t rsp
);

  localparam int STEPS = pidcc_pkg::PROD_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam int TW    = pidcc_pkg::TIME_W;
  localparam int PW    = pidcc_pkg::PROD_W;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [TW-1:0]    rem;
  logic [TW-1:0]    rem_next;
  logic [PW-1:0]    quo;
  logic [PW-1:0]    quo_next;
  logic [TW-1:0]    divisor;

  // two dependent restoring steps on a 31-bit remainder
  always_comb begin
    logic [TW:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_next, quo_next[PW-1]};
      quo_next = {quo_next[PW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = TW'(trial - {1'b0, divisor});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/pid_controller_clamped_core.sv =====
// pid_controller_clamped_core: top level of the fixed-point pid controller.
// Depends on pidcc_pkg, pidcc_mul and pidcc_div.
//
// usage
//   input channel: setpoint, measured, step_time under in_valid / in_ready.
//   one beat in gives exactly one drive beat out under out_valid / out_ready.
//   configuration: cfg_we writes cfg_data into register cfg_index
//   (0 gain_p, 1 gain_i, 2 gain_d, 3/4 drive limits, 5/6 integral
//   limits); write only while no beat is in flight.
//   per beat, the 64-by-31 derivative division runs two quotient bits a
//   cycle and takes the most time, while the shared multiplier takes the
//   p, derivative, integral-step and i products in turn.
//   a zero step_time beat skips all of that and returns 0.
//   throughput: one beat at a time; in_ready is high only in the idle state.
//   a finished drive waits in the output register, so the next beat can be
//   taken and computed while the receiver stalls; only the final load waits.
//   reset: gains clear, limits open to the full range, the accumulated error
//   and last error clear, and the first beat after reset has no derivative.
module pid_controller_clamped_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  setpoint,
  input  logic signed [31:0]                  measured,
  input  logic [30:0]                         step_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  drive,
  input  logic                                cfg_we,
  input  logic [pidcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int DW = pidcc_pkg::DATA_W;
  localparam int PW = pidcc_pkg::PROD_W;
  localparam int TW = pidcc_pkg::TIME_W;

  localparam logic signed [PW-1:0] S64_MAX = 64'sd2147483647;
  localparam logic signed [PW-1:0] S64_MIN = -64'sd2147483648;
  localparam logic signed [DW-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] S32_MIN = 32'sh80000000;
  localparam logic [PW-1:0] Q_POS_MAX = 64'h0000_0000_7fff_ffff;
  localparam logic [PW-1:0] Q_NEG_MAX = 64'h0000_0000_8000_0000;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MP   = 4'd1;
  localparam logic [3:0] S_MD   = 4'd2;
  localparam logic [3:0] S_ME   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_MI   = 4'd5;
  localparam logic [3:0] S_WI   = 4'd6;
  localparam logic [3:0] S_WAIT = 4'd7;
  localparam logic [3:0] S_DSAT = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;

  function automatic pidcc_pkg::data_t sat32(input pidcc_pkg::prod_t x);
    if (x > S64_MAX) return S32_MAX;
    if (x < S64_MIN) return S32_MIN;
    return x[DW-1:0];
  endfunction

  // fixed-point product: floor shift, then saturate
  function automatic pidcc_pkg::data_t fsat(input pidcc_pkg::prod_t x);
    pidcc_pkg::prod_t sh;
    sh = x >>> pidcc_pkg::FRAC_BITS;
    return sat32(sh);
  endfunction

  // with crossed limits, a value above hi gives hi and any other gives lo
  function automatic pidcc_pkg::data_t clampv(input pidcc_pkg::data_t v,
                                              input pidcc_pkg::data_t lo,
                                              input pidcc_pkg::data_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // configuration
  pidcc_pkg::data_t gain_p, gain_i, gain_d;
  pidcc_pkg::data_t out_lower, out_upper, acc_lower, acc_upper;

  // controller state
  pidcc_pkg::data_t error_sum, last_error;
  logic             first_step;

  // per-beat working registers
  logic [3:0]       state, state_next;
  pidcc_pkg::data_t err;
  logic [TW-1:0]    dt;
  logic             zero;
  pidcc_pkg::data_t p_term, i_term, d_term;
  logic             div_used, div_neg;

  pidcc_pkg::mul_req_t mul_req;
  pidcc_pkg::prod_t    prod;
  pidcc_pkg::div_req_t div_req;
  pidcc_pkg::div_rsp_t div_rsp;

  pidcc_pkg::data_t diff;
  pidcc_pkg::data_t err_in;
  pidcc_pkg::data_t acc_new;
  pidcc_pkg::data_t d_sat;
  pidcc_pkg::data_t y;
  logic             in_beat;
  logic             load_out;

  pidcc_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  pidcc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign load_out = (state == S_SUM) && (!out_valid || out_ready);

  assign err_in  = sat32(PW'(setpoint) - PW'(measured));
  assign diff    = sat32(PW'(err) - PW'(last_error));
  assign acc_new = clampv(sat32(PW'(error_sum) + PW'(fsat(prod))), acc_lower, acc_upper);
  assign y       = zero ? '0
                 : clampv(sat32(PW'(p_term) + PW'(i_term) + PW'(d_term)),
                          out_lower, out_upper);

  // derivative quotient back to signed, saturated to 32 bits
  always_comb begin
    if (!div_used) begin
      d_sat = '0;
    end else if (div_neg) begin
      d_sat = (div_rsp.quotient > Q_NEG_MAX) ? S32_MIN
            : DW'(-div_rsp.quotient[DW-1:0]);
    end else begin
      d_sat = (div_rsp.quotient > Q_POS_MAX) ? S32_MAX
            : div_rsp.quotient[DW-1:0];
    end
  end

  // operand routing for the shared multiplier
  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = err;
    mul_req.b  = gain_p;
    unique case (state)
      S_MP: begin
        mul_req.en = 1'b1;
      end
      S_MD: begin
        mul_req.en = 1'b1;
        mul_req.a  = gain_d;
        mul_req.b  = diff;
      end
      S_ME: begin
        mul_req.en = 1'b1;
        mul_req.b  = $signed({1'b0, dt});
      end
      S_MI: begin
        mul_req.en = 1'b1;
        mul_req.a  = gain_i;
        mul_req.b  = error_sum;
      end
      default: begin
      end
    endcase
  end

  // derivative division starts once gain_d * diff is out of the multiplier
  assign div_req.start    = (state == S_ME) && !first_step;
  assign div_req.dividend = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign div_req.divisor  = dt;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_beat) begin
        state_next = (step_time == '0) ? S_SUM : S_MP;
      end
      S_MP:   state_next = S_MD;
      S_MD:   state_next = S_ME;
      S_ME:   state_next = S_ACC;
      S_ACC:  state_next = S_MI;
      S_MI:   state_next = S_WI;
      S_WI:   state_next = S_WAIT;
      S_WAIT: if (!div_rsp.busy) begin
        state_next = S_DSAT;
      end
      S_DSAT: state_next = S_SUM;
      S_SUM:  if (load_out) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      error_sum  <= '0;
      last_error <= '0;
      first_step <= 1'b1;
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      out_lower  <= S32_MIN;
      out_upper  <= S32_MAX;
      acc_lower  <= S32_MIN;
      acc_upper  <= S32_MAX;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_ACC) begin
        error_sum  <= acc_new;
        last_error <= err;
        first_step <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pidcc_pkg::REG_GAIN_P:    gain_p    <= cfg_data;
          pidcc_pkg::REG_GAIN_I:    gain_i    <= cfg_data;
          pidcc_pkg::REG_GAIN_D:    gain_d    <= cfg_data;
          pidcc_pkg::REG_OUT_LOWER: out_lower <= cfg_data;
          pidcc_pkg::REG_OUT_UPPER: out_upper <= cfg_data;
          pidcc_pkg::REG_ACC_LOWER: acc_lower <= cfg_data;
          pidcc_pkg::REG_ACC_UPPER: acc_upper <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      err  <= err_in;
      dt   <= step_time;
      zero <= (step_time == '0);
    end
    if (state == S_MD) begin
      p_term <= fsat(prod);
    end
    if (state == S_ME) begin
      div_used <= !first_step;
      div_neg  <= prod[PW-1];
    end
    if (state == S_WI) begin
      i_term <= fsat(prod);
    end
    if (state == S_DSAT) begin
      d_term <= d_sat;
    end
    if (load_out) begin
      drive <= y;
    end
  end

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_dsat_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSAT) |-> !div_rsp.busy)
    else $error("derivative taken before division finished");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && state != S_ACC) |=> $stable(error_sum) && $stable(last_error))
    else $error("controller state changed outside the accumulate step");

  a_out_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_SUM)
    else $error("drive beat raised outside the sum step");
`endif

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for pid_controller_clamped_core
// holds a cycle-accurate-free predictor of the clamped pid math and checks every drive beat
// depends on pidcc_pkg and the rtl of pid_controller_clamped_core
`timescale 1ns / 100ps

module tb;

  // run limit, far above the slowest legal run (about 1900 beats
  // plus the longest sender gaps and receiver stalls)
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BEATS = 1850;
  localparam int RANDOM_PHASES = 8;
  localparam int TW = pidcc_pkg::TIME_W;

  // index past the last register, writes to it must be dropped
  localparam logic [pidcc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam pidcc_pkg::data_t Q_MAX = 32'sh7FFF_FFFF;
  localparam pidcc_pkg::data_t Q_MIN = 32'sh8000_0000;
  localparam pidcc_pkg::data_t Q_ONE = 32'sh0001_0000;
  localparam logic [TW-1:0] STEP_MAX = 31'h7FFF_FFFF;
  localparam logic [TW-1:0] STEP_ONE = 31'h0001_0000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  pidcc_pkg::data_t  setpoint;
  pidcc_pkg::data_t  measured;
  logic [TW-1:0]     step_time;
  logic              out_valid;
  logic              out_ready;
  pidcc_pkg::data_t  drive;
  logic              cfg_we;
  logic [pidcc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]       cfg_data;

  pid_controller_clamped_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .setpoint  (setpoint),
    .measured  (measured),
    .step_time (step_time),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int cycle_count = 0;
  int fail_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // controller predictor: mirrors of the registers and the loop state
  // ---------------------------------------------------------------------
  longint kp, ki, kd;          // gains, signed q16.16
  longint drv_lo, drv_hi;      // drive limits
  longint acc_lo, acc_hi;      // accumulated error limits
  longint acc_err;             // accumulated error
  longint prev_err;            // error of the last nonzero step
  bit     first_beat;          // no derivative until one step has run

  pidcc_pkg::data_t drive_expect_q[$];

  function automatic longint sat32(longint x);
    if (x > longint'(Q_MAX)) return longint'(Q_MAX);
    if (x < longint'(Q_MIN)) return longint'(Q_MIN);
    return x;
  endfunction

  // fixed-point product: exact, floor shift, then saturate
  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> pidcc_pkg::FRAC_BITS);
  endfunction

  // with crossed limits, a value above hi gives hi and any other gives lo
  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic pidcc_pkg::data_t pid_predict(pidcc_pkg::data_t sp,
                                                   pidcc_pkg::data_t ms,
                                                   logic [TW-1:0] dt);
    longint err, p, d, dtl;
    dtl = {33'd0, dt};
    // zero step time: drive 0 and the state is left alone
    if (dtl == 0) return '0;
    err = sat32(longint'(sp) - longint'(ms));
    p = qmul(kp, err);
    d = 0;
    // derivative uses the full 64-bit product, divided with truncation
    if (!first_beat) d = sat32((kd * sat32(err - prev_err)) / dtl);
    acc_err = clamp_range(sat32(acc_err + qmul(err, dtl)), acc_lo, acc_hi);
    prev_err = err;
    first_beat = 1'b0;
    return pidcc_pkg::data_t'(clamp_range(sat32(p + qmul(ki, acc_err) + d),
                                          drv_lo, drv_hi));
  endfunction

  function automatic void apply_reg(logic [pidcc_pkg::CFG_IDX_W-1:0] idx,
                                    pidcc_pkg::data_t value);
    case (idx)
      pidcc_pkg::REG_GAIN_P:    kp = value;
      pidcc_pkg::REG_GAIN_I:    ki = value;
      pidcc_pkg::REG_GAIN_D:    kd = value;
      pidcc_pkg::REG_OUT_LOWER: drv_lo = value;
      pidcc_pkg::REG_OUT_UPPER: drv_hi = value;
      pidcc_pkg::REG_ACC_LOWER: acc_lo = value;
      pidcc_pkg::REG_ACC_UPPER: acc_hi = value;
      default: ;  // unmapped index, nothing changes
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // drive beat checker, sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (drive_expect_q.size() == 0) begin
        $error("drive beat with no expected value: actual %0d", drive);
        fail_count++;
      end else begin
        pidcc_pkg::data_t want;
        want = drive_expect_q.pop_front();
        if (drive !== want) begin
          $error("drive mismatch: expected %0d, actual %0d", want, drive);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: stall pattern that switches between modes after runs of
  // random length, from always-ready to long back-pressure
  // ---------------------------------------------------------------------
  initial begin
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 15) == 0);
        default: out_ready <= (mode_left % 64 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  int burst_left = 0;

  // one input beat; bursts of random length, random gaps between them
  task automatic send_sample(pidcc_pkg::data_t sp, pidcc_pkg::data_t ms,
                             logic [TW-1:0] dt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    setpoint  <= sp;
    measured  <= ms;
    step_time <= dt;
    do @(posedge clk); while (!in_ready);
    drive_expect_q.push_back(pid_predict(sp, ms, dt));
    burst_left--;
  endtask

  // hold the sender until every expected drive beat has come back
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
  endtask

  // registers only change while nothing is in flight
  task automatic write_reg(logic [pidcc_pkg::CFG_IDX_W-1:0] idx,
                           pidcc_pkg::data_t value);
    drain_pipeline();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, value);
  endtask

  // mixed value source: extremes, full range, and a few units around zero
  function automatic pidcc_pkg::data_t pick_value();
    int small_val;
    small_val = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return small_val;
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_step();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 31'd1;
      2: return STEP_MAX;
      3, 4, 5: return TW'($urandom);
      default: return TW'($urandom_range(1, 32'h0004_0000));
    endcase
  endfunction

  function automatic pidcc_pkg::data_t pick_gain();
    int mid_val;
    mid_val = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
      2: return '0;
      default: return mid_val;
    endcase
  endfunction

  // a limit pair: mostly ordered, sometimes wide open, sometimes crossed
  task automatic write_limits(logic [pidcc_pkg::CFG_IDX_W-1:0] lo_idx,
                              logic [pidcc_pkg::CFG_IDX_W-1:0] hi_idx);
    pidcc_pkg::data_t a, b;
    a = pick_value();
    b = pick_value();
    case ($urandom_range(0, 5))
      0: begin
        write_reg(lo_idx, Q_MIN);
        write_reg(hi_idx, Q_MAX);
      end
      1: begin
        write_reg(lo_idx, (a > b) ? a : b);
        write_reg(hi_idx, (a > b) ? b : a);
      end
      default: begin
        write_reg(lo_idx, (a > b) ? b : a);
        write_reg(hi_idx, (a > b) ? a : b);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // first beat after reset has no derivative; a zero step before it keeps that
  task automatic test_first_step();
    write_reg(pidcc_pkg::REG_GAIN_P, Q_ONE);
    write_reg(pidcc_pkg::REG_GAIN_I, 32'sh0000_8000);
    write_reg(pidcc_pkg::REG_GAIN_D, 32'sh0002_0000);
    send_sample(32'sh0003_0000, Q_ONE, '0);
    send_sample(32'sh0003_0000, Q_ONE, STEP_ONE);
    send_sample(Q_ONE, 32'sh0002_8000, 31'h0000_8000);
  endtask

  // field extremes: saturated error, huge derivative, longest step
  task automatic test_field_extremes();
    write_reg(pidcc_pkg::REG_GAIN_P, Q_MAX);
    write_reg(pidcc_pkg::REG_GAIN_I, Q_MIN);
    write_reg(pidcc_pkg::REG_GAIN_D, Q_MAX);
    send_sample(Q_MAX, Q_MIN, 31'd1);
    send_sample(Q_MIN, Q_MAX, STEP_MAX);
    send_sample('0, '0, STEP_MAX);
    send_sample(Q_MIN, '0, 31'd1);
    send_sample(-1, Q_MAX, STEP_MAX);
    send_sample(Q_MAX, Q_MAX, 31'd1);
  endtask

  // crossed and equal limits, plus a write to the unmapped index
  task automatic test_crossed_limits();
    write_reg(pidcc_pkg::REG_GAIN_P, Q_ONE);
    write_reg(pidcc_pkg::REG_GAIN_I, Q_ONE);
    write_reg(pidcc_pkg::REG_GAIN_D, '0);
    write_reg(pidcc_pkg::REG_OUT_LOWER, 32'sh0064_0000);
    write_reg(pidcc_pkg::REG_OUT_UPPER, 32'shFF9C_0000);
    write_reg(pidcc_pkg::REG_ACC_LOWER, Q_ONE);
    write_reg(pidcc_pkg::REG_ACC_UPPER, -Q_ONE);
    write_reg(REG_SPARE, $urandom);
    send_sample(32'sh0200_0000, '0, STEP_ONE);
    send_sample(32'shFE00_0000, '0, STEP_ONE);
    send_sample('0, '0, STEP_ONE);
    // zero step still gives zero outside the drive limits
    send_sample(32'sh0200_0000, '0, '0);
    write_reg(pidcc_pkg::REG_OUT_LOWER, 32'sh0005_0000);
    write_reg(pidcc_pkg::REG_OUT_UPPER, 32'sh0005_0000);
    send_sample(Q_MAX, Q_MIN, STEP_ONE);
    send_sample(Q_MIN, Q_MAX, STEP_ONE);
  endtask

  // zero step with the error at its ends, full limits back in place
  task automatic test_zero_step();
    write_reg(pidcc_pkg::REG_OUT_LOWER, Q_MIN);
    write_reg(pidcc_pkg::REG_OUT_UPPER, Q_MAX);
    write_reg(pidcc_pkg::REG_ACC_LOWER, Q_MIN);
    write_reg(pidcc_pkg::REG_ACC_UPPER, Q_MAX);
    send_sample(Q_MAX, Q_MIN, '0);
    send_sample(Q_MIN, Q_MAX, '0);
  endtask

  // random phases: new registers each phase, mostly a plant that tracks
  // its setpoint at a fixed step, with noise beats mixed in
  task automatic test_random();
    pidcc_pkg::data_t track_sp, track_ms;
    logic [TW-1:0] track_dt;
    int jitter, hold_at, per_phase;
    per_phase = RANDOM_BEATS / RANDOM_PHASES;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(pidcc_pkg::REG_GAIN_P, pick_gain());
      write_reg(pidcc_pkg::REG_GAIN_I, pick_gain());
      write_reg(pidcc_pkg::REG_GAIN_D, pick_gain());
      write_limits(pidcc_pkg::REG_OUT_LOWER, pidcc_pkg::REG_OUT_UPPER);
      write_limits(pidcc_pkg::REG_ACC_LOWER, pidcc_pkg::REG_ACC_UPPER);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
      track_sp = pick_value();
      track_ms = pick_value();
      track_dt = TW'($urandom_range(1, 32'h0002_0000));
      hold_at = $urandom_range(20, per_phase - 20);
      for (int n = 0; n < per_phase; n++) begin
        // pressure point: sender waits for the pipe to empty
        if (n == hold_at) drain_pipeline();
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 39) == 0) track_sp = pick_value();
          jitter = int'($urandom_range(0, 2048)) - 1024;
          track_ms = pidcc_pkg::data_t'(sat32(longint'(track_ms) + jitter
                     + ((longint'(track_sp) - longint'(track_ms)) >>> 3)));
          send_sample(track_sp, track_ms, track_dt);
        end else begin
          send_sample(pick_value(), pick_value(), pick_step());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    setpoint  = '0;
    measured  = '0;
    step_time = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // predictor state after reset
    kp = 0;
    ki = 0;
    kd = 0;
    drv_lo = Q_MIN;
    drv_hi = Q_MAX;
    acc_lo = Q_MIN;
    acc_hi = Q_MAX;
    acc_err = 0;
    prev_err = 0;
    first_beat = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_step();
    test_field_extremes();
    test_crossed_limits();
    test_zero_step();
    test_random();

    // let the last beats come home, then watch for strays
    drain_pipeline();
    repeat (100) @(posedge clk);

    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pidcc_pkg.sv
rtl/pidcc_mul.sv
rtl/pidcc_div.sv
rtl/pid_controller_clamped_core.sv
verif/tb.sv
